// ===== hw/rtl/absd_pkg.sv =====
// Package for the A/B boot slot decision: types, codes and the decision function.
`timescale 1ns / 1ps

package absd_pkg;

  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [CountW-1:0] ConfirmReset  = 4'd3;
  localparam logic [CountW-1:0] RollbackReset = 4'd2;

  localparam logic [CfgIdxW-1:0] CfgConfirm  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgRollback = 4'd1;

  typedef enum logic [1:0] {
    BootIdle       = 2'd0,
    BootUpgradeReq = 2'd1,
    BootTransfer   = 2'd2,
    BootPending    = 2'd3
  } boot_state_e;

  typedef enum logic [1:0] {
    ActJump    = 2'd0,
    ActUpgrade = 2'd1,
    ActWait    = 2'd2
  } boot_action_e;

  // Stored boot parameter record
  typedef struct packed {
    boot_state_e        state;
    logic               act_slot;
    logic               pend_slot;
    logic               try_slot;
    logic [CountW-1:0]  miss_cnt;
    logic [CountW-1:0]  good_cnt;
    logic               boot_ok;
  } absd_rec_t;

  // One input word: record plus boot-time status
  typedef struct packed {
    logic      record_valid;
    absd_rec_t rec;
    logic      upg_key;
    logic      slot_valid_a;
    logic      slot_valid_b;
  } absd_in_t;

  // One result word
  typedef struct packed {
    absd_rec_t    rec;
    logic         write_record;
    boot_action_e action;
    logic         jump_slot;
  } absd_out_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Full decision for one record
  function automatic absd_out_t decide(input absd_in_t in_w,
                                       input logic [CountW-1:0] confirm_thr,
                                       input logic [CountW-1:0] rollback_thr);
    absd_rec_t    r;
    absd_out_t    res;
    logic         wr;
    logic         clr;
    logic         slot;
    logic         good;
    logic         other_good;
    boot_action_e act;
    r    = in_w.rec;
    wr   = 1'b0;
    clr  = 1'b0;
    act  = ActJump;
    slot = 1'b0;

    // replace an unreadable record by defaults
    if (!in_w.record_valid) begin
      r  = '{state: BootIdle, default: '0};
      wr = 1'b1;
    end

    // evaluate the pending activation
    if (r.state == BootPending) begin
      wr = 1'b1;
      if (r.pend_slot == r.act_slot && r.try_slot == r.act_slot) begin
        if (r.boot_ok) begin
          r.good_cnt = sat_inc(r.good_cnt);
          r.boot_ok  = 1'b0;
          clr        = (r.good_cnt >= confirm_thr);
        end else begin
          r.good_cnt = '0;
          r.miss_cnt = sat_inc(r.miss_cnt);
          if (r.miss_cnt >= rollback_thr) begin
            r.act_slot = ~r.act_slot;
            clr        = 1'b1;
          end
        end
      end else begin
        clr       = 1'b1;
        r.boot_ok = 1'b0;
      end
      if (clr) begin
        r.state     = BootIdle;
        r.pend_slot = 1'b0;
        r.try_slot  = 1'b0;
        r.miss_cnt  = '0;
        r.good_cnt  = '0;
      end
    end

    // pick the boot action
    if (in_w.upg_key || r.state == BootUpgradeReq) begin
      act = ActUpgrade;
    end else begin
      good       = r.act_slot ? in_w.slot_valid_b : in_w.slot_valid_a;
      other_good = r.act_slot ? in_w.slot_valid_a : in_w.slot_valid_b;
      slot       = r.act_slot;
      if (!good) begin
        if (other_good) begin
          r.act_slot = ~r.act_slot;
          r.state    = BootIdle;
          wr         = 1'b1;
          slot       = r.act_slot;
        end else begin
          act = ActWait;
        end
      end
      if (act == ActJump && r.state == BootPending) begin
        r.try_slot = slot;
        r.boot_ok  = 1'b0;
        wr         = 1'b1;
      end
    end

    res.rec          = r;
    res.write_record = wr;
    res.action       = act;
    res.jump_slot    = (act == ActJump) ? slot : 1'b0;
    return res;
  endfunction

endpackage

// ===== hw/rtl/ab_boot_slot_decision.sv =====
// Top level of the A/B boot slot decision: input register, decision logic, result register.
`timescale 1ns / 1ps

// Takes one boot parameter record per word and returns the updated record, a
// write-back flag and the boot action (jump, upgrade mode or wait). A word is
// accepted in every cycle while the result side keeps up; each word passes
// through two registers, first the input register and then the result
// register, with the whole decision done in the logic between them. The
// threshold registers are written through the configuration port, which is
// always ready; write them only while no word is in flight.
module ab_boot_slot_decision (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [absd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [absd_pkg::CountW-1:0]  cfg_data_i,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         record_valid_i,
  input  logic [1:0]                   boot_state_i,
  input  logic                         active_slot_in_i,
  input  logic                         pending_slot_in_i,
  input  logic                         attempt_slot_in_i,
  input  logic [absd_pkg::CountW-1:0]  attempt_count_in_i,
  input  logic [absd_pkg::CountW-1:0]  success_count_in_i,
  input  logic                         boot_ok_in_i,
  input  logic                         key_pressed_i,
  input  logic                         slot_valid_a_i,
  input  logic                         slot_valid_b_i,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   state_out_o,
  output logic                         active_slot_out_o,
  output logic                         pending_slot_out_o,
  output logic                         attempt_slot_out_o,
  output logic [absd_pkg::CountW-1:0]  attempt_count_out_o,
  output logic [absd_pkg::CountW-1:0]  success_count_out_o,
  output logic                         boot_ok_out_o,
  output logic                         write_record_o,
  output logic [1:0]                   boot_action_o,
  output logic                         jump_slot_o
);

  logic [absd_pkg::CountW-1:0] confirm_q, confirm_d;
  logic [absd_pkg::CountW-1:0] rollback_q, rollback_d;

  logic                 in_vld_q, in_vld_d;
  absd_pkg::absd_in_t   in_q, in_d;
  logic                 res_vld_q, res_vld_d;
  absd_pkg::absd_out_t  res_q, res_d;

  logic                 res_load;
  logic                 in_load;
  absd_pkg::absd_out_t  dec;

  // threshold registers
  assign cfg_ready = 1'b1;

  always_comb begin
    confirm_d  = confirm_q;
    rollback_d = rollback_q;
    if (cfg_valid) begin
      if (cfg_index_i == absd_pkg::CfgConfirm) begin
        confirm_d = cfg_data_i;
      end else if (cfg_index_i == absd_pkg::CfgRollback) begin
        rollback_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q  <= absd_pkg::ConfirmReset;
      rollback_q <= absd_pkg::RollbackReset;
    end else begin
      confirm_q  <= confirm_d;
      rollback_q <= rollback_d;
    end
  end

  // advance when the stage ahead is free or draining
  assign res_load = !res_vld_q || !out_stall;
  assign in_load  = !in_vld_q || res_load;
  assign in_stall = !in_load;

  // capture the input word
  always_comb begin
    in_vld_d = in_load ? in_valid : in_vld_q;
    in_d     = in_q;
    if (in_load && in_valid) begin
      in_d.record_valid   = record_valid_i;
      in_d.rec.state      = absd_pkg::boot_state_e'(boot_state_i);
      in_d.rec.act_slot   = active_slot_in_i;
      in_d.rec.pend_slot  = pending_slot_in_i;
      in_d.rec.try_slot   = attempt_slot_in_i;
      in_d.rec.miss_cnt   = attempt_count_in_i;
      in_d.rec.good_cnt   = success_count_in_i;
      in_d.rec.boot_ok    = boot_ok_in_i;
      in_d.upg_key        = key_pressed_i;
      in_d.slot_valid_a   = slot_valid_a_i;
      in_d.slot_valid_b   = slot_valid_b_i;
    end
  end

  // decide and hold the result
  assign dec = absd_pkg::decide(in_q, confirm_q, rollback_q);

  always_comb begin
    res_vld_d = res_load ? in_vld_q : res_vld_q;
    res_d     = (res_load && in_vld_q) ? dec : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  // drive the result word
  assign out_valid           = res_vld_q;
  assign state_out_o         = res_q.rec.state;
  assign active_slot_out_o   = res_q.rec.act_slot;
  assign pending_slot_out_o  = res_q.rec.pend_slot;
  assign attempt_slot_out_o  = res_q.rec.try_slot;
  assign attempt_count_out_o = res_q.rec.miss_cnt;
  assign success_count_out_o = res_q.rec.good_cnt;
  assign boot_ok_out_o       = res_q.rec.boot_ok;
  assign write_record_o      = res_q.write_record;
  assign boot_action_o       = res_q.action;
  assign jump_slot_o         = res_q.jump_slot;

  // stall only when both stages hold a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> (in_vld_q && res_vld_q && out_stall))
    else $error("input stalled with a free stage");

  // a word in the input register moves on when the result side is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && res_load) |=> out_valid)
    else $error("word lost between stages");

  // only a jump names a slot
  a_jump_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && boot_action_o != absd_pkg::ActJump) |-> !jump_slot_o)
    else $error("jump slot set without a jump");

  // a record left pending is consistent and has its report flag cleared
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && state_out_o == absd_pkg::BootPending) |->
      (attempt_slot_out_o == active_slot_out_o &&
       pending_slot_out_o == active_slot_out_o && !boot_ok_out_o && write_record_o))
    else $error("inconsistent pending record");

  // an upgrade request always enters upgrade mode
  a_upgrade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && state_out_o == absd_pkg::BootUpgradeReq) |->
      (boot_action_o == absd_pkg::ActUpgrade))
    else $error("upgrade request without upgrade action");

endmodule
